>>> sv/u8d_pkg.sv
`default_nettype none
package u8d_pkg;

  localparam int INDEX_WIDTH_DEFAULT = 32;
  localparam int CP_WIDTH = 21;
  localparam int IDX_OUT_WIDTH = 32;

  localparam logic [7:0] LEAD1_MASK = 8'h7F;
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] LEAD1_PAT  = 8'h00;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [1:0] CONT_TAG   = 2'b10;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [CP_WIDTH-1:0]      code_point;
    logic [2:0]               unit_count;
    logic                     invalid;
    logic [IDX_OUT_WIDTH-1:0] point_index;
    logic                     last_of_run;
  } out_t;

  // results caused by one byte: a run of invalid zeros, then an optional tail result
  typedef struct packed {
    logic [2:0]          inv_count;
    logic                tail_valid;
    logic [CP_WIDTH-1:0] tail_cp;
    logic [2:0]          tail_units;
    logic                tail_invalid;
  } run_t;

endpackage
`default_nettype wire

>>> sv/u8d_decode.sv
`default_nettype none
module u8d_decode
  import u8d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire in_t  item,
  output run_t      run
);

  logic [2:0]          expected_length, expected_length_next;
  logic [1:0]          bytes_taken, bytes_taken_next;
  logic [CP_WIDTH-1:0] partial_value, partial_value_next;

  logic [7:0]          b;
  logic                pend;
  logic                cont;
  logic [2:0]          taken_inc;
  logic [CP_WIDTH-1:0] pv_shift;
  logic [2:0]          lead_len;
  logic [7:0]          lead_bits;

  assign b         = item.stream_byte;
  assign pend      = (expected_length != 3'd0);
  assign cont      = (b[7:6] == CONT_TAG);
  assign taken_inc = {1'b0, bytes_taken} + 3'd1;
  assign pv_shift  = {partial_value[CP_WIDTH-7:0], b[5:0]};

  always_comb begin
    if ((b & ~LEAD1_MASK) == LEAD1_PAT) begin
      lead_len  = 3'd1;
      lead_bits = b & LEAD1_MASK;
    end else if ((b & ~LEAD2_MASK) == LEAD2_PAT) begin
      lead_len  = 3'd2;
      lead_bits = b & LEAD2_MASK;
    end else if ((b & ~LEAD3_MASK) == LEAD3_PAT) begin
      lead_len  = 3'd3;
      lead_bits = b & LEAD3_MASK;
    end else if ((b & ~LEAD4_MASK) == LEAD4_PAT) begin
      lead_len  = 3'd4;
      lead_bits = b & LEAD4_MASK;
    end else begin
      lead_len  = 3'd0;
      lead_bits = 8'h00;
    end
  end

  always_comb begin
    run                  = '0;
    expected_length_next = expected_length;
    bytes_taken_next     = bytes_taken;
    partial_value_next   = partial_value;
    if (pend && cont) begin
      if (taken_inc >= expected_length) begin
        run.tail_valid       = 1'b1;
        run.tail_cp          = pv_shift;
        run.tail_units       = expected_length;
        expected_length_next = 3'd0;
        bytes_taken_next     = 2'd0;
        partial_value_next   = '0;
      end else if (item.end_of_stream) begin
        run.inv_count        = taken_inc;
        expected_length_next = 3'd0;
        bytes_taken_next     = 2'd0;
        partial_value_next   = '0;
      end else begin
        bytes_taken_next   = taken_inc[1:0];
        partial_value_next = pv_shift;
      end
    end else begin
      // broken sequence flushes the taken bytes first
      run.inv_count        = pend ? {1'b0, bytes_taken} : 3'd0;
      expected_length_next = 3'd0;
      bytes_taken_next     = 2'd0;
      partial_value_next   = '0;
      case (lead_len)
        3'd1: begin
          run.tail_valid = 1'b1;
          run.tail_cp    = CP_WIDTH'(b);
          run.tail_units = 3'd1;
        end
        3'd0: begin
          run.tail_valid   = 1'b1;
          run.tail_units   = 3'd1;
          run.tail_invalid = 1'b1;
        end
        default: begin
          if (item.end_of_stream) begin
            run.inv_count = run.inv_count + 3'd1;
          end else begin
            expected_length_next = lead_len;
            bytes_taken_next     = 2'd1;
            partial_value_next   = CP_WIDTH'(lead_bits);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 3'd0;
      bytes_taken     <= 2'd0;
      partial_value   <= '0;
    end else if (advance) begin
      expected_length <= expected_length_next;
      bytes_taken     <= bytes_taken_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/utf8_stream_decoder_core.sv
`default_nettype none
// path: an input byte is held in the hold stage, then in the results stage
// throughput: one byte per cycle without out_stall; a byte that causes n
// results (up to 4) holds its results stage, one result transfer per cycle
// reset: rst clears the pending sequence, the result index and both stages
module utf8_stream_decoder_core
  import u8d_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic                   hold_valid;
  in_t                    hold;
  run_t                   run_new;
  logic                   run_busy;
  logic [2:0]             inv_left;
  logic                   tail_pending;
  run_t                   run_reg;
  logic                   out_last;
  logic                   out_xfer;
  logic                   run_free;
  logic                   advance;
  logic                   in_xfer;
  logic                   new_has_result;
  logic [INDEX_WIDTH-1:0] result_counter;
  logic [IDX_OUT_WIDTH-1:0] index_out;

  u8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold),
    .run     (run_new)
  );

  assign run_busy       = (inv_left != 3'd0) || tail_pending;
  assign out_last       = (inv_left == 3'd1 && !tail_pending) || (inv_left == 3'd0);
  assign out_xfer       = run_busy && !out_stall;
  assign run_free       = !run_busy || (out_xfer && out_last);
  assign advance        = hold_valid && run_free;
  assign in_stall       = hold_valid && !run_free;
  assign in_xfer        = in_valid && !in_stall;
  assign new_has_result = (run_new.inv_count != 3'd0) || run_new.tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_xfer) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_left     <= 3'd0;
      tail_pending <= 1'b0;
    end else if (advance) begin
      inv_left     <= new_has_result ? run_new.inv_count : 3'd0;
      tail_pending <= run_new.tail_valid;
    end else if (out_xfer) begin
      if (inv_left != 3'd0) begin
        inv_left <= inv_left - 3'd1;
      end else begin
        tail_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      run_reg <= run_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_counter <= '0;
    end else if (out_xfer) begin
      result_counter <= result_counter + INDEX_WIDTH'(1);
    end
  end

  generate
    if (INDEX_WIDTH >= IDX_OUT_WIDTH) begin : g_idx_trunc
      assign index_out = result_counter[IDX_OUT_WIDTH-1:0];
    end else begin : g_idx_ext
      assign index_out = {{(IDX_OUT_WIDTH-INDEX_WIDTH){1'b0}}, result_counter};
    end
  endgenerate

  always_comb begin
    out_valid            = run_busy;
    out_data.point_index = index_out;
    out_data.last_of_run = out_last;
    if (inv_left != 3'd0) begin
      out_data.code_point = '0;
      out_data.unit_count = 3'd1;
      out_data.invalid    = 1'b1;
    end else begin
      out_data.code_point = run_reg.tail_cp;
      out_data.unit_count = run_reg.tail_units;
      out_data.invalid    = run_reg.tail_invalid;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/utf8_stream_decoder_core_test.sv
`timescale 1ns / 1ps
module utf8_stream_decoder_core_test
  import u8d_pkg::*;
;

  localparam int RANDOM_BYTES   = 196;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  class utf8_scoreboard;
    out_t expected_q[$];
    out_t run_q[$];
    logic [2:0] seq_len;
    int unsigned taken;
    logic [CP_WIDTH-1:0] partial;
    logic [IDX_OUT_WIDTH-1:0] next_index;
    int mismatches;
    int bytes_seen;
    int results_seen;
    int invalid_seen;
    int multi_seen;

    function new();
      seq_len = '0;
      taken = 0;
      partial = '0;
      next_index = '0;
      mismatches = 0;
      bytes_seen = 0;
      results_seen = 0;
      invalid_seen = 0;
      multi_seen = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void push_result(logic [CP_WIDTH-1:0] cp, logic [2:0] units, logic bad);
      out_t r;
      r.code_point = cp;
      r.unit_count = units;
      r.invalid = bad;
      r.point_index = next_index;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
      next_index = next_index + 1'b1;
    endfunction

    // every byte taken so far comes out as one invalid zero
    function void flush_taken();
      for (int k = 0; k < taken; k++) push_result('0, 3'd1, 1'b1);
      seq_len = '0;
      taken = 0;
      partial = '0;
    endfunction

    function void note_byte(in_t item);
      logic [7:0] b;
      logic handled;
      out_t tail;
      b = item.stream_byte;
      handled = 1'b0;
      bytes_seen++;
      run_q.delete();
      if (seq_len != 0) begin
        if (b[7:6] == CONT_TAG) begin
          partial = {partial[CP_WIDTH-7:0], b[5:0]};
          taken++;
          if (taken >= seq_len) begin
            push_result(partial, seq_len, 1'b0);
            seq_len = '0;
            taken = 0;
            partial = '0;
          end
          handled = 1'b1;
        end else begin
          flush_taken();
        end
      end
      if (!handled) begin
        if ((b & ~LEAD1_MASK) == LEAD1_PAT) begin
          push_result(CP_WIDTH'(b), 3'd1, 1'b0);
        end else if ((b & ~LEAD2_MASK) == LEAD2_PAT) begin
          seq_len = 3'd2;
          taken = 1;
          partial = CP_WIDTH'(b & LEAD2_MASK);
        end else if ((b & ~LEAD3_MASK) == LEAD3_PAT) begin
          seq_len = 3'd3;
          taken = 1;
          partial = CP_WIDTH'(b & LEAD3_MASK);
        end else if ((b & ~LEAD4_MASK) == LEAD4_PAT) begin
          seq_len = 3'd4;
          taken = 1;
          partial = CP_WIDTH'(b & LEAD4_MASK);
        end else begin
          push_result('0, 3'd1, 1'b1);
        end
      end
      if (item.end_of_stream && seq_len != 0) flush_taken();
      if (run_q.size() > 0) begin
        tail = run_q.pop_back();
        tail.last_of_run = 1'b1;
        run_q.push_back(tail);
      end
      foreach (run_q[k]) expected_q.push_back(run_q[k]);
    endfunction

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (got.invalid === 1'b1) invalid_seen++;
      if (got.unit_count > 3'd1) multi_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: cp=%h idx=%0d",
                                  got.code_point, got.point_index));
        return;
      end
      want = expected_q.pop_front();
      if (got.code_point !== want.code_point)
        report_mismatch($sformatf("idx %0d code_point %h, want %h",
                                  want.point_index, got.code_point, want.code_point));
      if (got.unit_count !== want.unit_count)
        report_mismatch($sformatf("idx %0d unit_count %0d, want %0d",
                                  want.point_index, got.unit_count, want.unit_count));
      if (got.invalid !== want.invalid)
        report_mismatch($sformatf("idx %0d invalid %b, want %b",
                                  want.point_index, got.invalid, want.invalid));
      if (got.point_index !== want.point_index)
        report_mismatch($sformatf("point_index %0d, want %0d",
                                  got.point_index, want.point_index));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("idx %0d last_of_run %b, want %b",
                                  want.point_index, got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_active = 1'b0;
  int idle_cycles = 0;
  utf8_scoreboard sb;

  // ascii extremes, each sequence length, stray and illegal bytes,
  // broken sequences and end of stream inside a sequence
  in_t dir_items [24] = '{
    {8'h00, 1'b0}, {8'h7F, 1'b0},
    {8'hC2, 1'b0}, {8'hA9, 1'b0},
    {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
    {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
    {8'h80, 1'b0}, {8'hF8, 1'b0}, {8'hFF, 1'b0},
    {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'h41, 1'b0},
    {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'hC3, 1'b1},
    {8'hC3, 1'b1},
    {8'hE2, 1'b0}, {8'h82, 1'b1}
  };

  utf8_stream_decoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] lead_byte(int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1: return LEAD1_PAT | (LEAD1_MASK & r);
      2: return LEAD2_PAT | (LEAD2_MASK & r);
      3: return LEAD3_PAT | (LEAD3_MASK & r);
      default: return LEAD4_PAT | (LEAD4_MASK & r);
    endcase
  endfunction

  task automatic send_item(input in_t item);
    if (!quiet && !hold_req && !hold_active && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(item);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] seq_q[$];
    logic [7:0] b;
    int kind;
    int len;
    int sent;
    bit held;
    bit drained;
    sb = new();
    sent = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_items[i]) send_item(dir_items[i]);

    while (sent < RANDOM_BYTES) begin
      seq_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = $urandom_range(1, 4);
        seq_q.push_back(lead_byte(len));
        repeat (len - 1) seq_q.push_back({CONT_TAG, 6'($urandom)});
      end else if (kind < 80) begin
        // sequence cut short by a byte that is no continuation
        len = $urandom_range(2, 4);
        seq_q.push_back(lead_byte(len));
        repeat ($urandom_range(0, len - 2)) seq_q.push_back({CONT_TAG, 6'($urandom)});
        b = 8'($urandom);
        if (b[7:6] == CONT_TAG) b[6] = 1'b1;
        seq_q.push_back(b);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 3)) seq_q.push_back({CONT_TAG, 6'($urandom)});
      end else begin
        repeat ($urandom_range(1, 3)) seq_q.push_back(8'($urandom));
      end
      foreach (seq_q[k]) begin
        send_item({seq_q[k], 1'($urandom_range(0, 24) == 0)});
        sent++;
      end
      if (!held && sent >= 60) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && sent >= 130) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
      end
      if (sent >= RANDOM_BYTES - 40) quiet = 1'b1;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (8) @(posedge clk);

    $display("fed %0d stream bytes, %0d results checked (%0d invalid, %0d multi-byte)",
             sb.bytes_seen, sb.results_seen, sb.invalid_seen, sb.multi_seen);
    $display("covered broken and flushed sequences, stray bytes and a long result hold");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
